// ===== rtl/core/dq_pkg.sv =====
// shared types and constants for the double-ended queue
// holds command and status codes, sizes and the cell control struct
// no dependencies
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] push_value;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/dq_cell.sv =====
// one storage cell of the queue chain
// holds one value and an occupied flag, shifts with its neighbors
// depends on dq_pkg
module dq_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dq_pkg::cell_ctrl_t           ctrl,
    input  logic signed [dq_pkg::DATA_W-1:0] left_value,
    input  logic                         left_occ,
    input  logic signed [dq_pkg::DATA_W-1:0] right_value,
    input  logic                         right_occ,
    output logic signed [dq_pkg::DATA_W-1:0] value_out,
    output logic                         occ_out,
    output logic signed [dq_pkg::DATA_W-1:0] tail_tap
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     is_tail;
    logic                     is_free_head;

    // this cell is the back item, or the first free slot after it
    assign is_tail      = occ_reg & ~right_occ;
    assign is_free_head = left_occ & ~occ_reg;

    // next value and occupancy per operation
    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        unique case (ctrl.op)
            OP_PUSH_FRONT:
            begin
                value_next = left_value;
                occ_next   = left_occ;
            end
            OP_PUSH_BACK:
            begin
                if (is_free_head)
                begin
                    value_next = ctrl.push_value;
                    occ_next   = 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                value_next = right_value;
                occ_next   = right_occ;
            end
            OP_POP_BACK:
            begin
                if (is_tail)
                begin
                    occ_next = 1'b0;
                end
            end
            default:
            begin
                value_next = value_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    // occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // stored value
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_out = value_reg;
    assign occ_out   = occ_reg;
    assign tail_tap  = is_tail ? value_reg : '0;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// top level of the double-ended queue: command decode, count and result
// register around a chain of dq_cell storage cells
// depends on dq_pkg and dq_cell
//
//  channel  | handshake      | fields
//  ---------+----------------+----------------------------
//  command  | start / busy   | cmd, value
//  result   | done (strobe)  | data, item_total, status
//
// one item per cycle; busy stays low, the chain updates in the cycle of accept
// the result shows on done in the cycle after the item is accepted
// the front is always cell 0; a push at the front or a pop at the front
// shifts the whole chain by one cell; a back pop touches only the tail cell, a back push the first free cell
// reset clears the occupied flags and the count; cell values stay undefined
// the receiver cannot stall; every result is presented for a single cycle
module double_ended_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dq_pkg::CMD_W-1:0]          cmd,
    input  logic signed [dq_pkg::DATA_W-1:0]  value,
    output logic                              done,
    output logic signed [dq_pkg::DATA_W-1:0]  data,
    output logic [dq_pkg::CNT_W-1:0]          item_total,
    output logic [dq_pkg::STAT_W-1:0]         status
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic                     cell_occ   [DEPTH];
    logic signed [DATA_W-1:0] cell_tap   [DEPTH];
    cell_ctrl_t               ctrl;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CNT_W-1:0]         total_reg;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic signed [DATA_W-1:0] tail_value;
    logic                     accept;
    logic                     is_empty;
    logic                     is_full;

    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // gather the back item from the one tail cell
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tap[i];
        end
    end

    // command decode
    always_comb
    begin
        ctrl.op         = OP_NONE;
        ctrl.push_value = value;
        data_next       = '0;
        status_next     = STAT_OK;
        count_next      = count_reg;
        if (accept)
        begin
            unique case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctrl.op    = (cmd == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                        count_next = count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT, CMD_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        data_next = cell_value[0];
                        if (cmd == CMD_POP_FRONT)
                        begin
                            ctrl.op    = OP_POP_FRONT;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                CMD_POP_BACK, CMD_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        data_next = tail_value;
                        if (cmd == CMD_POP_BACK)
                        begin
                            ctrl.op    = OP_POP_BACK;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    ctrl.op = OP_NONE;
                end
            endcase
        end
    end

    // chain of cells, cell 0 holds the front
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] lv;
        logic                     lo;
        logic signed [DATA_W-1:0] rv;
        logic                     ro;

        if (i == 0)
        begin : g_head
            assign lv = value;
            assign lo = 1'b1;
        end
        else
        begin : g_mid
            assign lv = cell_value[i-1];
            assign lo = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign rv = '0;
            assign ro = 1'b0;
        end
        else
        begin : g_link
            assign rv = cell_value[i+1];
            assign ro = cell_occ[i+1];
        end

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_value  (lv),
            .left_occ    (lo),
            .right_value (rv),
            .right_occ   (ro),
            .value_out   (cell_value[i]),
            .occ_out     (cell_occ[i]),
            .tail_tap    (cell_tap[i])
        );
    end

    // count and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        total_reg  <= count_next;
        status_reg <= status_next;
    end

    assign done       = done_reg;
    assign data       = data_reg;
    assign item_total = total_reg;
    assign status     = status_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for double_ended_queue: directed and random command streams
// checked against an in-bench deque model; depends on dq_pkg and double_ended_queue
module testbench;

    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDX_W = $clog2(DEPTH);

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [DATA_W-1:0]  value;
        bit                        hold_for_drain;
        bit                        may_idle;
    } dq_item_t;

    typedef struct {
        logic signed [DATA_W-1:0]  data;
        logic [CNT_W-1:0]          item_total;
        logic [STAT_W-1:0]         status;
    } dq_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          cmd;
    logic signed [DATA_W-1:0]  value;
    logic                      done;
    logic signed [DATA_W-1:0]  data;
    logic [CNT_W-1:0]          item_total;
    logic [STAT_W-1:0]         status;

    // pending commands, expected results and progress counters
    dq_item_t    pending_q[$];
    dq_result_t  expected_results[$];
    int          items_sent;
    int          results_seen;
    int          mismatch_count;
    int          cycle_count;

    // deque model state
    logic signed [DATA_W-1:0]  model_slots [DEPTH];
    int                        model_head;
    int                        model_held;

    // stimulus generator's view of the occupancy
    int                        gen_held;

    double_ended_queue u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .value      (value),
        .done       (done),
        .data       (data),
        .item_total (item_total),
        .status     (status)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // apply one command to the model and return what the block should answer
    function automatic dq_result_t apply_command(dq_item_t it);
        dq_result_t r;
        logic [IDX_W-1:0] slot;
        r.data   = '0;
        r.status = STAT_OK;
        case (it.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (model_held >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (it.cmd == CMD_PUSH_FRONT)
                    begin
                        model_head = (model_head + DEPTH - 1) % DEPTH;
                        slot = IDX_W'(model_head);
                    end
                    else
                        slot = IDX_W'((model_head + model_held) % DEPTH);
                    model_slots[slot] = it.value;
                    model_held++;
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT:
            begin
                if (model_held == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    slot = IDX_W'(model_head);
                    r.data = model_slots[slot];
                    if (it.cmd == CMD_POP_FRONT)
                    begin
                        model_head = (model_head + 1) % DEPTH;
                        model_held--;
                    end
                end
            end
            CMD_POP_BACK, CMD_PEEK_BACK:
            begin
                if (model_held == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    slot = IDX_W'((model_head + model_held - 1) % DEPTH);
                    r.data = model_slots[slot];
                    if (it.cmd == CMD_POP_BACK)
                        model_held--;
                end
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase
        r.item_total = CNT_W'(model_held);
        return r;
    endfunction

    // random push value, leaning toward the extremes now and then
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // queue one command and keep track of the occupancy it leads to
    task automatic add_item(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                            input bit hold);
        dq_item_t it;
        it.cmd            = c;
        it.value          = v;
        it.hold_for_drain = hold;
        // a long stretch of back-to-back items in the middle of the run
        it.may_idle       = !(pending_q.size() >= 200 && pending_q.size() < 320);
        pending_q.push_back(it);
        case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: if (gen_held < DEPTH) gen_held++;
            CMD_POP_FRONT, CMD_POP_BACK:   if (gen_held > 0) gen_held--;
            default: ;
        endcase
    endtask

    // driver: one item per accept, random gaps, one hold until all results are back
    always @(posedge clk)
    begin : drive_commands
        bit accepted;
        bit go;
        int outstanding;
        dq_item_t it;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            accepted = start && !busy;
            if (accepted)
            begin
                it = pending_q.pop_front();
                expected_results.push_back(apply_command(it));
                items_sent <= items_sent + 1;
            end
            outstanding = items_sent + int'(accepted) - results_seen;
            // an item refused by busy stays on the ports
            if (!(start && !accepted))
            begin
                go = 1'b0;
                if (pending_q.size() > 0)
                begin
                    go = 1'b1;
                    if (pending_q[0].hold_for_drain && outstanding != 0)
                        go = 1'b0;
                    if (pending_q[0].may_idle && $urandom_range(0, 99) < 25)
                        go = 1'b0;
                end
                start <= go;
                if (go)
                begin
                    cmd   <= pending_q[0].cmd;
                    value <= pending_q[0].value;
                end
            end
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin : check_results
        dq_result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (results_seen >= items_sent)
            begin
                $error("result with no item outstanding: data %0d count %0d status %0d",
                       data, item_total, status);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results[results_seen];
                if (data !== exp_r.data)
                begin
                    $error("data mismatch: expected %0d, got %0d", exp_r.data, data);
                    mismatch_count++;
                end
                if (item_total !== exp_r.item_total)
                begin
                    $error("item_total mismatch: expected %0d, got %0d",
                           exp_r.item_total, item_total);
                    mismatch_count++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", exp_r.status, status);
                    mismatch_count++;
                end
                results_seen <= results_seen + 1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus and end of test
    initial
    begin : run_test
        int round;
        int n;
        int kind;
        logic [CMD_W-1:0] c;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        value          = '0;
        items_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        model_head     = 0;
        model_held     = 0;
        gen_held       = 0;

        // directed: empty accesses, unused codes, extreme values, both ends
        add_item(CMD_POP_FRONT, '0, 1'b0);
        add_item(CMD_POP_BACK, '1, 1'b0);
        add_item(CMD_PEEK_FRONT, '0, 1'b0);
        add_item(CMD_PEEK_BACK, '0, 1'b0);
        add_item(CMD_SPARE_A, '0, 1'b0);
        add_item(CMD_SPARE_B, '1, 1'b0);
        add_item(CMD_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        add_item(CMD_PUSH_BACK, {1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        add_item(CMD_PUSH_FRONT, '0, 1'b0);
        add_item(CMD_PUSH_BACK, '1, 1'b0);
        add_item(CMD_PEEK_FRONT, '0, 1'b0);
        add_item(CMD_PEEK_BACK, '0, 1'b0);
        add_item(CMD_POP_FRONT, '0, 1'b0);
        add_item(CMD_POP_BACK, '0, 1'b0);
        add_item(CMD_SPARE_A, '1, 1'b0);
        add_item(CMD_POP_FRONT, '0, 1'b0);
        add_item(CMD_POP_BACK, '0, 1'b0);
        add_item(CMD_PEEK_BACK, '0, 1'b0);

        // random: fill runs, drain runs, mixed traffic and a little noise
        round = 0;
        n = pending_q.size() + RANDOM_ITEMS;
        while (pending_q.size() < n)
        begin
            kind = (round == 0) ? 0 : (round == 1) ? 4 : $urandom_range(0, 9);
            if (kind <= 2)
            begin
                // push until full, then a few pushes that must be refused
                while (gen_held < DEPTH)
                    add_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                             pick_value(), 1'b0);
                repeat ($urandom_range(1, 3))
                    add_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                             pick_value(), 1'b0);
            end
            else if (kind <= 5)
            begin
                // pops with peeks mixed in until empty, then accesses on empty
                while (gen_held > 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       c = CMD_PEEK_FRONT;
                        1:       c = CMD_PEEK_BACK;
                        2, 3:    c = CMD_POP_FRONT;
                        default: c = CMD_POP_BACK;
                    endcase
                    add_item(c, pick_value(), 1'b0);
                end
                repeat ($urandom_range(1, 2))
                    add_item(CMD_POP_FRONT + CMD_W'($urandom_range(0, 3)), pick_value(),
                             1'b0);
            end
            else if (kind <= 8)
            begin
                repeat ($urandom_range(10, 30))
                    add_item(CMD_W'($urandom_range(0, 5)), pick_value(), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(3, 8))
                    add_item(CMD_W'($urandom_range(0, 7)), pick_value(), 1'b0);
            end
            // hold the sender once until every result is back
            if (round == 3)
                pending_q[pending_q.size()-1].hold_for_drain = 1'b1;
            round++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() > 0 || start)
            @(posedge clk);
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (results_seen != items_sent)
        begin
            $error("%0d expected results never arrived", items_sent - results_seen);
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
